[design/pafc_pkg.sv]
// shared types and constants of the partition allocator
package pafc_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam logic [15:0] RESET_TOTAL_KB = 16'd10240;

  // request codes, the spare code behaves as compact
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_COMPACT = 2'd2,
    REQ_SPARE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_FRAG      = 3'd1,
    ST_OOM       = 3'd2,
    ST_FREED     = 3'd3,
    ST_COMPACTED = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CFG_FIT_POLICY = 1'b0,
    CFG_TOTAL_KB   = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SW_SCAN  = 2'd0,
    SW_FREE  = 2'd1,
    SW_PACK  = 2'd2,
    SW_SHIFT = 2'd3
  } sweep_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GO,
    S_WAIT,
    S_PICK,
    S_SHIFT_GO,
    S_SHIFT_WAIT,
    S_SPLIT,
    S_TAIL,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic        is_free;
    logic [7:0]  owner;
  } entry_t;

  typedef struct packed {
    logic        req_ld;
    logic        sweep_go;
    sweep_mode_t mode;
    logic        pick_wr;
    logic        split_wr;
    logic        tail_wr;
    logic        result_ld;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic found;
    logic split;
    req_t req_kind;
    logic out_free;
  } sts_t;

endpackage

[design/pafc_ctrl.sv]
// request sequencer of the partition allocator
module pafc_ctrl import pafc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_GO;
      end
      S_GO: state_next = S_WAIT;
      S_WAIT: begin
        if (!sts.busy) begin
          case (sts.req_kind)
            REQ_ALLOC: state_next = sts.found ? S_PICK : S_RESULT;
            REQ_FREE:  state_next = S_RESULT;
            default:   state_next = S_TAIL;
          endcase
        end
      end
      S_PICK: state_next = sts.split ? S_SHIFT_GO : S_RESULT;
      S_SHIFT_GO: state_next = S_SHIFT_WAIT;
      S_SHIFT_WAIT: begin
        if (!sts.busy) state_next = S_SPLIT;
      end
      S_SPLIT: state_next = S_RESULT;
      S_TAIL: state_next = S_RESULT;
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.mode = SW_SCAN;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.req_ld = in_valid;
      S_GO: begin
        cmd.sweep_go = 1'b1;
        case (sts.req_kind)
          REQ_ALLOC: cmd.mode = SW_SCAN;
          REQ_FREE:  cmd.mode = SW_FREE;
          default:   cmd.mode = SW_PACK;
        endcase
      end
      S_PICK: cmd.pick_wr = 1'b1;
      S_SHIFT_GO: begin
        cmd.sweep_go = 1'b1;
        cmd.mode = SW_SHIFT;
      end
      S_SPLIT: cmd.split_wr = 1'b1;
      S_TAIL: cmd.tail_wr = 1'b1;
      S_RESULT: cmd.result_ld = sts.out_free;
      default: cmd.mode = SW_SCAN;
    endcase
  end

endmodule

[design/pafc_dp.sv]
// partition table memory, sweep pipeline and totals
module pafc_dp import pafc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  req_type,
  input  logic [7:0]  owner_id,
  input  logic [15:0] size_kb,
  input  logic        out_stall,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [15:0] block_start,
  output logic [15:0] amount_kb,
  output logic [15:0] free_total_kb,
  output logic        fragmented
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;
  entry_t wd;
  logic             we;
  logic [IDX_W-1:0] wa;

  logic             fit_policy;
  logic [CNT_W-1:0] count;
  logic [15:0]      free_kb;
  logic             frag;
  req_t             req_kind;
  logic [7:0]       owner;
  logic [15:0]      need;

  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rd_left;
  logic             ev_vld;
  logic [IDX_W-1:0] ev_ptr;
  sweep_mode_t      mode_q;

  logic             found;
  logic [IDX_W-1:0] pick;
  logic [15:0]      pick_start;
  logic [15:0]      pick_size;
  logic [15:0]      best_diff;
  logic [15:0]      freed;
  logic [15:0]      offset;
  logic [CNT_W-1:0] active;

  logic        restart;
  logic        fits;
  logic [15:0] diff;
  logic        tail_ok;

  assign restart = cfg_we && (cfg_index == CFG_TOTAL_KB);
  assign fits    = rdata.is_free && (rdata.size >= need);
  assign diff    = rdata.size - need;
  assign tail_ok = (free_kb != 16'd0) && (active < FULL);

  // memory write port
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (rst || restart) begin
      we = 1'b1;
      wd.size = rst ? RESET_TOTAL_KB : cfg_data;
      wd.is_free = 1'b1;
    end else if (ev_vld && mode_q == SW_FREE) begin
      if (!rdata.is_free && rdata.owner == owner) begin
        we = 1'b1;
        wa = ev_ptr;
        wd.start = rdata.start;
        wd.size = rdata.size;
        wd.is_free = 1'b1;
      end
    end else if (ev_vld && mode_q == SW_PACK) begin
      if (!rdata.is_free) begin
        we = 1'b1;
        wa = active[IDX_W-1:0];
        wd = rdata;
        wd.start = offset;
      end
    end else if (ev_vld && mode_q == SW_SHIFT) begin
      we = 1'b1;
      wa = ev_ptr + IDX_W'(1);
      wd = rdata;
    end else if (cmd.pick_wr) begin
      we = 1'b1;
      wa = pick;
      wd.start = pick_start;
      wd.size = need;
      wd.owner = owner;
    end else if (cmd.split_wr) begin
      we = 1'b1;
      wa = pick + IDX_W'(1);
      wd.start = pick_start + need;
      wd.size = pick_size - need;
      wd.is_free = 1'b1;
    end else if (cmd.tail_wr && tail_ok) begin
      we = 1'b1;
      wa = active[IDX_W-1:0];
      wd.start = offset;
      wd.size = free_kb;
      wd.is_free = 1'b1;
    end
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_left != '0) rdata <= mem[rd_ptr];
  end

  // sweep read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_left <= '0;
      ev_vld <= 1'b0;
      mode_q <= SW_SCAN;
    end else if (cmd.sweep_go) begin
      mode_q <= cmd.mode;
      ev_vld <= 1'b0;
      if (cmd.mode == SW_SHIFT) begin
        rd_ptr <= IDX_W'(count - CNT_W'(1));
        rd_left <= count - CNT_W'(1) - CNT_W'(pick);
      end else begin
        rd_ptr <= '0;
        rd_left <= count;
      end
    end else begin
      ev_vld <= (rd_left != '0);
      ev_ptr <= rd_ptr;
      if (rd_left != '0) begin
        rd_left <= rd_left - CNT_W'(1);
        rd_ptr <= (mode_q == SW_SHIFT) ? rd_ptr - IDX_W'(1) : rd_ptr + IDX_W'(1);
      end
    end
  end

  // request latch and per-sweep accumulators
  always_ff @(posedge clk) begin
    if (cmd.req_ld) begin
      req_kind <= req_t'(req_type);
      owner <= owner_id;
      need <= size_kb;
    end
    if (cmd.sweep_go && cmd.mode != SW_SHIFT) begin
      found <= 1'b0;
      freed <= '0;
      offset <= '0;
      active <= '0;
    end else if (ev_vld) begin
      case (mode_q)
        SW_SCAN: begin
          if (fits && (!found || (fit_policy && diff < best_diff))) begin
            found <= 1'b1;
            pick <= ev_ptr;
            best_diff <= diff;
            pick_start <= rdata.start;
            pick_size <= rdata.size;
          end
        end
        SW_FREE: begin
          if (!rdata.is_free && rdata.owner == owner) freed <= freed + rdata.size;
        end
        SW_PACK: begin
          if (!rdata.is_free) begin
            offset <= offset + rdata.size;
            active <= active + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // configuration, table count, free total and fragmentation flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= 1'b0;
      count <= CNT_W'(1);
      free_kb <= RESET_TOTAL_KB;
      frag <= 1'b0;
    end else if (restart) begin
      count <= CNT_W'(1);
      free_kb <= cfg_data;
      frag <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FIT_POLICY) fit_policy <= cfg_data[0];
      if (ev_vld && mode_q == SW_FREE && !rdata.is_free && rdata.owner == owner) begin
        free_kb <= free_kb + rdata.size;
      end
      if (cmd.pick_wr) free_kb <= free_kb - need;
      if (cmd.split_wr) count <= count + CNT_W'(1);
      if (cmd.tail_wr) begin
        count <= active + CNT_W'(tail_ok);
        frag <= 1'b0;
      end
      if (cmd.result_ld && req_kind == REQ_ALLOC && !found && free_kb >= need) frag <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_ld) begin
      block_start <= '0;
      amount_kb <= '0;
      free_total_kb <= free_kb;
      fragmented <= frag;
      case (req_kind)
        REQ_ALLOC: begin
          if (found) begin
            status <= ST_ALLOCATED;
            block_start <= pick_start;
            amount_kb <= need;
          end else if (free_kb >= need) begin
            status <= ST_FRAG;
            fragmented <= 1'b1;
          end else begin
            status <= ST_OOM;
          end
        end
        REQ_FREE: begin
          status <= ST_FREED;
          amount_kb <= freed;
        end
        default: status <= ST_COMPACTED;
      endcase
    end
  end

  assign sts.busy = (rd_left != '0) || ev_vld;
  assign sts.found = found;
  assign sts.split = (pick_size != need) && (count < FULL);
  assign sts.req_kind = req_kind;
  assign sts.out_free = !out_valid || !out_stall;

  // the table never holds more entries than it has rows
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("partition count beyond table size");
  // a shift only runs while the table has a free row
  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.sweep_go && cmd.mode == SW_SHIFT) |-> (count < FULL && found))
    else $error("split shift without room");
  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.result_ld)
    else $error("result register overwritten");

endmodule

[design/partition_allocator_fit_compact.sv]
// Partition allocator with first-fit or best-fit placement and compaction.
// One request is handled at a time. The table sits in a single-port-write,
// single-read memory and every request sweeps it at one entry a cycle. An
// allocate whose leftover is split off into a new entry sweeps it once more,
// from the last entry down to the one after the pick, moving each up a row.
// The result sits in an output register, so the next request is taken while
// it waits. Writing total_kb restarts the table as one free block.
module partition_allocator_fit_compact import pafc_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  owner_id,
  input  logic [15:0] size_kb,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] block_start,
  output logic [15:0] amount_kb,
  output logic [15:0] free_total_kb,
  output logic        fragmented
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  pafc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and arithmetic
  pafc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .owner_id      (owner_id),
    .size_kb       (size_kb),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .status        (status),
    .block_start   (block_start),
    .amount_kb     (amount_kb),
    .free_total_kb (free_total_kb),
    .fragmented    (fragmented)
  );

endmodule
